// ===== design/mbps_pkg.sv =====
// mbps_pkg: shared types and constants for the masked byte pattern search
// holds the configuration record, the queue entry record and the register codes
// no dependencies

package mbps_pkg;

   // bytes of pattern held in configuration registers; positions above are wildcards
   localparam int PATTERN_REG_BYTES = 24;

   // entries of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // width of the csr register index
   localparam int CSR_INDEX_BITS = 3;

   // widest configuration register
   localparam int CSR_DATA_BITS = 64;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PATTERN_LOW  = 3'd0,
      REG_PATTERN_MID  = 3'd1,
      REG_PATTERN_HIGH = 3'd2,
      REG_CARE_MASK    = 3'd3,
      REG_LENGTH       = 3'd4,
      REG_REF_MODE     = 3'd5,
      REG_REF_OFFSET   = 3'd6,
      REG_ADJUST       = 3'd7
   } mbps_csr_index_type;

   // result modes; the unused code behaves as plain
   typedef enum logic [1:0] {
      REF_PLAIN    = 2'd0,
      REF_RELATIVE = 2'd1,
      REF_ABSOLUTE = 2'd2
   } mbps_ref_mode_type;

   // configuration record
   typedef struct packed {
      logic [PATTERN_REG_BYTES-1:0][7:0] pattern;
      logic [PATTERN_REG_BYTES-1:0]      care;
      logic [4:0]                        length;
      logic [1:0]                        mode;
      logic [4:0]                        offset;
      logic [31:0]                       adjust;
   } mbps_cfg_type;

   // classified transaction handed from front to back
   typedef struct packed {
      logic        found;
      logic [31:0] disp;
   } mbps_entry_type;

endpackage

// ===== design/mbps_front.sv =====
// mbps_front: byte window, scan tracking and parallel masked compare
// classifies each byte as match, not-found or nothing and builds the queue entry
// depends on mbps_pkg

module mbps_front #(
   parameter int PATTERN_MAX  = 24,
   parameter int ADDRESS_BITS = 48
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [7:0]                 data_byte,
   input  logic [ADDRESS_BITS-1:0]    byte_address,
   input  logic                       last_byte,
   input  mbps_pkg::mbps_cfg_type     cfg,
   output logic                       push,
   output mbps_pkg::mbps_entry_type   entry,
   output logic [ADDRESS_BITS-1:0]    entry_base
);

   localparam int CNT_BITS = $clog2(PATTERN_MAX + 1);
   localparam int IDX_BITS = $clog2(PATTERN_MAX);
   localparam int CHECK_BYTES = (PATTERN_MAX < mbps_pkg::PATTERN_REG_BYTES) ?
                                PATTERN_MAX : mbps_pkg::PATTERN_REG_BYTES;

   logic [7:0]          window_ff [PATTERN_MAX];
   logic [7:0]          window_in [PATTERN_MAX];
   logic [7:0]          aligned   [PATTERN_MAX];
   logic [CNT_BITS-1:0] bytes_seen_ff, bytes_seen_in, seen_count;
   logic                search_done_ff, search_done_in;
   logic [5:0]          len_wide;
   logic [CNT_BITS-1:0] eff_len;
   logic                match_ok, match;
   logic [31:0]         disp_raw;
   logic signed [6:0]   start_delta, ref_delta;
   logic [ADDRESS_BITS-1:0] start_addr, ref_addr;

   // effective pattern length, clamped to 1..PATTERN_MAX
   always_comb begin
      if (cfg.length == 5'd0) begin
         len_wide = 6'd1;
      end else if ({1'b0, cfg.length} > 6'(PATTERN_MAX)) begin
         len_wide = 6'(PATTERN_MAX);
      end else begin
         len_wide = {1'b0, cfg.length};
      end
      eff_len = len_wide[CNT_BITS-1:0];
   end

   // window after this byte, newest at index 0
   always_comb begin
      window_in[0] = data_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   // window bytes in pattern order for the match ending at the newest byte
   always_comb begin
      logic [5:0] pos;
      for (int p = 0; p < PATTERN_MAX; p++) begin
         pos = len_wide - 6'd1 - 6'(p);
         if (6'(p) < len_wide) begin
            aligned[p] = window_in[pos[IDX_BITS-1:0]];
         end else begin
            aligned[p] = 8'h00;
         end
      end
   end

   // masked compare over all pattern positions at once
   always_comb begin
      match_ok = 1'b1;
      for (int p = 0; p < CHECK_BYTES; p++) begin
         if (6'(p) < len_wide && cfg.care[p] && aligned[p] != cfg.pattern[p]) begin
            match_ok = 1'b0;
         end
      end
   end

   // saturating byte count of the current scan
   assign seen_count = (bytes_seen_ff == CNT_BITS'(PATTERN_MAX)) ?
                       bytes_seen_ff : bytes_seen_ff + 1'b1;
   assign match = !search_done_ff && (seen_count >= eff_len) && match_ok;

   // little-endian displacement; bytes past the match read as zero
   always_comb begin
      logic [5:0] dpos;
      for (int j = 0; j < 4; j++) begin
         dpos = {1'b0, cfg.offset} + 6'(j);
         if (dpos < len_wide) begin
            disp_raw[8*j +: 8] = aligned[dpos[IDX_BITS-1:0]];
         end else begin
            disp_raw[8*j +: 8] = 8'h00;
         end
      end
   end

   // match start and displacement address as small signed offsets from this byte
   assign start_delta = 7'sd1 - signed'({1'b0, len_wide});
   assign ref_delta   = start_delta + signed'({2'b00, cfg.offset});
   assign start_addr  = byte_address + {{(ADDRESS_BITS-7){start_delta[6]}}, start_delta};
   assign ref_addr    = byte_address + {{(ADDRESS_BITS-7){ref_delta[6]}}, ref_delta};

   // classification and queue entry
   always_comb begin
      push       = 1'b0;
      entry      = '0;
      entry_base = '0;
      if (match) begin
         push        = accept;
         entry.found = 1'b1;
         case (cfg.mode)
            mbps_pkg::REF_RELATIVE: begin
               entry_base = ref_addr;
               entry.disp = disp_raw;
            end
            mbps_pkg::REF_ABSOLUTE: begin
               entry.disp = disp_raw;
            end
            default: begin
               entry_base = start_addr;
            end
         endcase
      end else if (last_byte && !search_done_ff) begin
         push = accept;
      end
   end

   // scan state next values
   assign search_done_in = last_byte ? 1'b0 : (search_done_ff | match);
   assign bytes_seen_in  = last_byte ? '0 : seen_count;

   // scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff  <= '0;
         search_done_ff <= 1'b0;
      end else if (accept) begin
         bytes_seen_ff  <= bytes_seen_in;
         search_done_ff <= search_done_in;
      end
   end

   // byte window, only compared once filled for the current scan
   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

   // a finished scan has always counted at least one byte
   a_done_has_bytes: assert property (@(posedge clock) disable iff (reset)
      search_done_ff |-> bytes_seen_ff != '0)
      else $error("search done with empty scan count");

   // the last byte of a scan always leaves the scan state clear
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> !search_done_ff && bytes_seen_ff == '0)
      else $error("scan state not cleared after last byte");

endmodule

// ===== design/mbps_queue.sv =====
// mbps_queue: short queue between the front and back parts
// register-based ring of classified transactions
// depends on mbps_pkg

module mbps_queue #(
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic                 pop_valid,
   output logic [DATA_BITS-1:0] pop_data,
   output logic                 full
);

   localparam int DEPTH    = mbps_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   // status
   assign pop_valid = (count_ff != '0);
   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign pop_data  = mem[rd_ptr_ff];

   // pointer and count next values
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   // front must hold off while the queue is full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   // back only takes what is there
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");

endmodule

// ===== design/mbps_back.sv =====
// mbps_back: resolves the location and holds the result register
// adds base address, displacement and adjustment, drives the rsp channel
// depends on mbps_pkg

module mbps_back #(
   parameter int ADDRESS_BITS = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  mbps_pkg::mbps_entry_type entry,
   input  logic [ADDRESS_BITS-1:0]  entry_base,
   input  logic [31:0]              adjust,
   output logic                     pop,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic                     rsp_found,
   output logic [63:0]              rsp_location
);

   logic        rsp_valid_ff;
   logic        rsp_found_ff;
   logic [63:0] rsp_location_ff, rsp_location_in;

   // load when the result register is empty or being taken
   assign pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   // location: base plus sign-extended displacement and adjustment
   always_comb begin
      if (entry.found) begin
         rsp_location_in = 64'(entry_base)
                         + {{32{entry.disp[31]}}, entry.disp}
                         + {{32{adjust[31]}}, adjust};
      end else begin
         rsp_location_in = '0;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_found_ff    <= entry.found;
         rsp_location_ff <= rsp_location_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_location = rsp_location_ff;

   // not-found transactions always carry a zero location
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_location_ff == 64'd0)
      else $error("not-found result with nonzero location");

endmodule

// ===== design/masked_byte_pattern_search.sv =====
// Masked byte pattern search: takes one byte per cycle while req_stall is low, with
// its address and last-byte flag, compares the newest pattern_length bytes against
// the configured pattern under the care mask, and returns one result per scan: found
// with the resolved location (match start, or a little-endian signed 32-bit
// displacement taken absolute or relative to its own address, plus the adjust
// register) or not-found at the last byte. The whole window compare finishes in the
// cycle of the byte; a result enters the queue when its byte is accepted and then the
// rsp output register, where rsp_stall can hold it. req_stall rises only when the
// two-entry result queue is full, which happens only while rsp_stall holds results
// back. Configuration is written through csr_write / csr_index / csr_wdata; the user
// must write it only while no transaction is in flight; the block does not enforce it.
// depends on mbps_pkg, mbps_front, mbps_queue, mbps_back

module masked_byte_pattern_search #(
   parameter int PATTERN_MAX  = 24,
   parameter int ADDRESS_BITS = 48
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_write,
   input  logic [mbps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   // byte stream
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_data_byte,
   input  logic [ADDRESS_BITS-1:0]               req_byte_address,
   input  logic                                  req_last_byte,
   // results
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic signed [63:0]                    rsp_location
);

   localparam int ENTRY_BITS = $bits(mbps_pkg::mbps_entry_type) + ADDRESS_BITS;

   mbps_pkg::mbps_cfg_type   cfg_ff, cfg_in;
   mbps_pkg::mbps_entry_type push_entry, pop_entry;
   logic [ADDRESS_BITS-1:0]  push_base, pop_base;
   logic                     accept, push, pop, pop_valid, full;
   logic [ENTRY_BITS-1:0]    pop_data;
   logic [63:0]              location;

   // configuration write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            mbps_pkg::REG_PATTERN_LOW:  cfg_in.pattern[7:0]   = csr_wdata;
            mbps_pkg::REG_PATTERN_MID:  cfg_in.pattern[15:8]  = csr_wdata;
            mbps_pkg::REG_PATTERN_HIGH: cfg_in.pattern[23:16] = csr_wdata;
            mbps_pkg::REG_CARE_MASK:    cfg_in.care   = csr_wdata[23:0];
            mbps_pkg::REG_LENGTH:       cfg_in.length = csr_wdata[4:0];
            mbps_pkg::REG_REF_MODE:     cfg_in.mode   = csr_wdata[1:0];
            mbps_pkg::REG_REF_OFFSET:   cfg_in.offset = csr_wdata[4:0];
            mbps_pkg::REG_ADJUST:       cfg_in.adjust = csr_wdata[31:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pattern: '0, care: '0, length: 5'd1, mode: mbps_pkg::REF_PLAIN,
                     offset: 5'd0, adjust: 32'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input handshake
   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   mbps_front #(
      .PATTERN_MAX  (PATTERN_MAX),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .byte_address (req_byte_address),
      .last_byte    (req_last_byte),
      .cfg          (cfg_ff),
      .push         (push),
      .entry        (push_entry),
      .entry_base   (push_base)
   );

   mbps_queue #(
      .DATA_BITS (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_entry, push_base}),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .full      (full)
   );

   // unpack queue head
   assign pop_entry = pop_data[ENTRY_BITS-1:ADDRESS_BITS];
   assign pop_base  = pop_data[ADDRESS_BITS-1:0];

   mbps_back #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (pop_valid),
      .entry        (pop_entry),
      .entry_base   (pop_base),
      .adjust       (cfg_ff.adjust),
      .pop          (pop),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_location (location)
   );

   assign rsp_location = signed'(location);

endmodule
